[rtl/subtitle_forced_object_counter_assert.svh]
// assertion macros for the subtitle forced object counter
// no dependencies; included by the top level only
`ifndef SUBTITLE_FORCED_OBJECT_COUNTER_ASSERT_SVH
`define SUBTITLE_FORCED_OBJECT_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
`define SFOC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfoc assertion failed");
`define SFOC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfoc assertion failed");
`else
`define SFOC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SFOC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/sfoc_pkg.sv]
// shared types and constants of the subtitle forced object counter
// no dependencies; used by sfoc_parser and the top level
package sfoc_pkg;

  localparam int COUNT_WIDTH_DEF = 32;
  localparam int OUT_WIDTH       = 32;
  localparam int CFG_IDX_W       = 2;

  localparam logic [15:0] MAGIC_RESET     = 16'h5047;
  localparam logic [7:0]  COMP_TYPE_RESET = 8'h16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COMP_TYPE = CFG_IDX_W'(1);

  // parser position codes above the header bytes
  localparam logic [3:0] POS_LAST_HDR = 4'd12;
  localparam logic [3:0] POS_FIELDS   = 4'd13;
  localparam logic [3:0] POS_ENTRIES  = 4'd14;
  localparam logic [3:0] POS_SKIP     = 4'd15;
  localparam logic [3:0] FIELD_LAST   = 4'd10;
  localparam logic [3:0] ENTRY_FLAG   = 4'd3;
  localparam logic [3:0] ENTRY_END    = 4'd7;
  localparam logic [3:0] CROP_END     = 4'd15;

  localparam int FORCED_BIT = 6;
  localparam int CROP_BIT   = 7;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_MAGIC = 2'd1,
    STATUS_TRUNC     = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] magic;
    logic [7:0]  comp_type;
  } cfg_t;

endpackage

[rtl/subtitle_forced_object_counter.sv]
// top level of the subtitle forced object counter: input and result registers,
// configuration registers; depends on sfoc_pkg, sfoc_parser and the assert header
//
// Usage: stream bytes on in_data_byte with in_valid; mark the final byte of a
// stream with in_last_byte. One result word (forced_count, object_count,
// parse_status) comes out for each final byte; other bytes give no result.
// Throughput is one byte per cycle while in_stall is low: the parser updates its
// position and counters from the byte held in the input register.
// out_valid rises as the result of a final byte in the input register is loaded.
// The result register holds one word; while it is stalled, non-final bytes
// keep flowing, and only a following final byte waits in the input register,
// which raises in_stall until out_stall drops.
// Configuration writes (magic_word at index 0, composition_type at index 1)
// are always ready and take effect at once; unknown indexes are dropped.
// Synchronous reset clears the parser state, both channels and restores the
// register defaults. After every report the parser starts a fresh stream.
module subtitle_forced_object_counter #(
  parameter int COUNT_WIDTH = sfoc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [31:0]                    out_forced_count,
  output logic [31:0]                    out_object_count,
  output logic [1:0]                     out_parse_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfoc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  `include "subtitle_forced_object_counter_assert.svh"

  sfoc_pkg::cfg_t         cfg_r;
  logic                   in_v_r;
  logic [7:0]             in_byte_r;
  logic                   in_last_r;
  logic                   advance;
  logic                   step;
  logic [COUNT_WIDTH-1:0] forced_nxt, object_nxt;
  sfoc_pkg::status_t      status_nxt;
  logic                   out_valid_r;
  logic [31:0]            forced_r, object_r;
  sfoc_pkg::status_t      status_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic     <= sfoc_pkg::MAGIC_RESET;
      cfg_r.comp_type <= sfoc_pkg::COMP_TYPE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sfoc_pkg::REG_MAGIC:     cfg_r.magic <= cfg_data;
        sfoc_pkg::REG_COMP_TYPE: cfg_r.comp_type <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // only a final byte needs the result register
  assign advance  = !(in_v_r && in_last_r && out_valid_r && out_stall);
  assign in_stall = !advance;
  assign step     = in_v_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) in_v_r <= 1'b0;
    else if (advance) in_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  sfoc_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .step      (step),
    .data_byte (in_byte_r),
    .last_byte (in_last_r),
    .forced_nxt(forced_nxt),
    .object_nxt(object_nxt),
    .status_nxt(status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (step && in_last_r) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step && in_last_r) begin
      forced_r <= 32'(forced_nxt);
      object_r <= 32'(object_nxt);
      status_r <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_forced_count = forced_r;
  assign out_object_count = object_r;
  assign out_parse_status = status_r;

  `SFOC_ASSERT_NXT(a_result_loaded, clk, rst_n, step && in_last_r, out_valid_r)
  `SFOC_ASSERT_NXT(a_result_kept, clk, rst_n, out_valid_r && out_stall, out_valid_r)
  `SFOC_ASSERT_IMP(a_status_code, clk, rst_n, out_valid_r, status_r != 2'd3)
  `SFOC_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall, in_v_r && out_valid_r)

endmodule

[rtl/sfoc_parser.sv]
// byte-wise segment parser: position tracking, object and forced counters
// depends on sfoc_pkg
module sfoc_parser #(
  parameter int COUNT_WIDTH = sfoc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sfoc_pkg::cfg_t         cfg,
  input  logic                   step,
  input  logic [7:0]             data_byte,
  input  logic                   last_byte,
  output logic [COUNT_WIDTH-1:0] forced_nxt,
  output logic [COUNT_WIDTH-1:0] object_nxt,
  output sfoc_pkg::status_t      status_nxt
);

  logic [3:0]             hp_r, hp_nxt;
  logic [7:0]             kind_r, kind_nxt;
  logic [15:0]            pl_r, pl_nxt;
  logic [3:0]             fp_r, fp_nxt;
  logic [7:0]             el_r, el_nxt;
  logic                   crop_r, crop_nxt;
  logic [COUNT_WIDTH-1:0] forced_r, object_r;
  sfoc_pkg::status_t      err_r, err_nxt;

  logic [COUNT_WIDTH:0]   obj_sum, frc_sum;

  assign obj_sum = {1'b0, object_r} + (COUNT_WIDTH+1)'(data_byte);
  assign frc_sum = {1'b0, forced_r} + (COUNT_WIDTH+1)'(1);

  always_comb begin
    hp_nxt     = hp_r;
    kind_nxt   = kind_r;
    pl_nxt     = pl_r;
    fp_nxt     = fp_r;
    el_nxt     = el_r;
    crop_nxt   = crop_r;
    forced_nxt = forced_r;
    object_nxt = object_r;
    err_nxt    = err_r;
    if (err_r == sfoc_pkg::STATUS_OK) begin
      if (hp_r <= sfoc_pkg::POS_LAST_HDR) begin
        hp_nxt = hp_r + 4'd1;
        if (hp_r == 4'd0 && data_byte != cfg.magic[15:8]) begin
          err_nxt = sfoc_pkg::STATUS_BAD_MAGIC;
          hp_nxt  = hp_r;
        end
        if (hp_r == 4'd1 && data_byte != cfg.magic[7:0]) begin
          err_nxt = sfoc_pkg::STATUS_BAD_MAGIC;
          hp_nxt  = hp_r;
        end
        if (hp_r == 4'd10) kind_nxt = data_byte;
        if (hp_r == 4'd11) pl_nxt = {data_byte, 8'h00};
        if (hp_r == sfoc_pkg::POS_LAST_HDR) begin
          pl_nxt   = {pl_r[15:8], data_byte};
          fp_nxt   = '0;
          el_nxt   = '0;
          crop_nxt = 1'b0;
          if ({pl_r[15:8], data_byte} == 16'd0) hp_nxt = 4'd0;
          else if (kind_r == cfg.comp_type) hp_nxt = sfoc_pkg::POS_FIELDS;
          else hp_nxt = sfoc_pkg::POS_SKIP;
        end
      end else begin
        pl_nxt = pl_r - 16'd1;
        if (hp_r == sfoc_pkg::POS_FIELDS) begin
          if (fp_r == sfoc_pkg::FIELD_LAST) begin
            object_nxt = obj_sum[COUNT_WIDTH] ? '1 : obj_sum[COUNT_WIDTH-1:0];
            el_nxt     = data_byte;
            fp_nxt     = '0;
            hp_nxt     = (data_byte == 8'd0) ? sfoc_pkg::POS_SKIP : sfoc_pkg::POS_ENTRIES;
          end else begin
            fp_nxt = fp_r + 4'd1;
          end
        end else if (hp_r == sfoc_pkg::POS_ENTRIES) begin
          if (fp_r == sfoc_pkg::ENTRY_FLAG) begin
            if (data_byte[sfoc_pkg::FORCED_BIT])
              forced_nxt = frc_sum[COUNT_WIDTH] ? '1 : frc_sum[COUNT_WIDTH-1:0];
            crop_nxt = data_byte[sfoc_pkg::CROP_BIT];
          end
          // entry ends after 8 bytes, or 16 with crop fields
          if (crop_nxt ? (fp_r == sfoc_pkg::CROP_END) : (fp_r >= sfoc_pkg::ENTRY_END)) begin
            fp_nxt   = '0;
            crop_nxt = 1'b0;
            el_nxt   = el_r - 8'd1;
            if (el_r == 8'd1) hp_nxt = sfoc_pkg::POS_SKIP;
          end else begin
            fp_nxt = fp_r + 4'd1;
          end
        end
        // payload used up: back to header whatever was in progress
        if (pl_r == 16'd1) begin
          hp_nxt   = 4'd0;
          fp_nxt   = '0;
          el_nxt   = '0;
          crop_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    status_nxt = err_nxt;
    if (err_nxt == sfoc_pkg::STATUS_OK &&
        ((hp_nxt != 4'd0 && hp_nxt <= sfoc_pkg::POS_LAST_HDR) ||
         hp_nxt == sfoc_pkg::POS_FIELDS))
      status_nxt = sfoc_pkg::STATUS_TRUNC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      hp_r     <= '0;
      kind_r   <= '0;
      pl_r     <= '0;
      fp_r     <= '0;
      el_r     <= '0;
      crop_r   <= 1'b0;
      forced_r <= '0;
      object_r <= '0;
      err_r    <= sfoc_pkg::STATUS_OK;
    end else if (step) begin
      hp_r     <= hp_nxt;
      kind_r   <= kind_nxt;
      pl_r     <= pl_nxt;
      fp_r     <= fp_nxt;
      el_r     <= el_nxt;
      crop_r   <= crop_nxt;
      forced_r <= forced_nxt;
      object_r <= object_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule

[tb/sfoc_report_checker.sv]
// report checker for the subtitle forced object counter: follows the byte and
// config channels, predicts each report and compares it with the result word
// depends on sfoc_pkg only
module sfoc_report_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_last_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [31:0]                    out_forced_count,
  input  logic [31:0]                    out_object_count,
  input  logic [1:0]                     out_parse_status,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [sfoc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data,
  output int                             fail_count,
  output int                             reports_pending,
  output int                             reports_checked,
  output int                             bad_magic_seen,
  output int                             trunc_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import sfoc_pkg::*;

  localparam logic [3:0] HDR_MAGIC_HI = 4'd0;
  localparam logic [3:0] HDR_MAGIC_LO = 4'd1;
  localparam logic [3:0] HDR_KIND     = 4'd10;
  localparam logic [3:0] HDR_SIZE_HI  = 4'd11;

  typedef struct packed {
    logic [31:0] forced;
    logic [31:0] objects;
    status_t     status;
  } report_t;

  logic [15:0] magic_q;
  logic [7:0]  comp_type_q;
  logic [3:0]  hdr_pos;
  logic [7:0]  seg_kind;
  logic [15:0] pay_left;
  logic [3:0]  fld_pos;
  logic [7:0]  ent_left;
  logic        ent_crop;
  logic [31:0] forced_tot;
  logic [31:0] object_tot;
  status_t     err;

  report_t pending_reports[$];
  int fails, checked, n_bad, n_trunc;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? '1 : sum[31:0];
  endfunction

  task automatic clear_parser();
    hdr_pos    = HDR_MAGIC_HI;
    seg_kind   = '0;
    pay_left   = '0;
    fld_pos    = '0;
    ent_left   = '0;
    ent_crop   = 1'b0;
    forced_tot = '0;
    object_tot = '0;
    err        = STATUS_OK;
  endtask

  task automatic parse_header_byte(input logic [7:0] b);
    if ((hdr_pos == HDR_MAGIC_HI && b != magic_q[15:8]) ||
        (hdr_pos == HDR_MAGIC_LO && b != magic_q[7:0])) begin
      err = STATUS_BAD_MAGIC;
    end else if (hdr_pos == POS_LAST_HDR) begin
      pay_left = {pay_left[15:8], b};
      fld_pos  = '0;
      ent_left = '0;
      ent_crop = 1'b0;
      if (pay_left == 16'd0) hdr_pos = HDR_MAGIC_HI;
      else if (seg_kind == comp_type_q) hdr_pos = POS_FIELDS;
      else hdr_pos = POS_SKIP;
    end else begin
      if (hdr_pos == HDR_KIND) seg_kind = b;
      if (hdr_pos == HDR_SIZE_HI) pay_left = {b, 8'h00};
      hdr_pos = hdr_pos + 4'd1;
    end
  endtask

  task automatic parse_payload_byte(input logic [7:0] b);
    pay_left = pay_left - 16'd1;
    if (hdr_pos == POS_FIELDS) begin
      if (fld_pos == FIELD_LAST) begin
        // declared count goes in at once, entries may never show up
        object_tot = sat_add(object_tot, {24'd0, b});
        ent_left   = b;
        fld_pos    = '0;
        hdr_pos    = (b == 8'd0) ? POS_SKIP : POS_ENTRIES;
      end else begin
        fld_pos = fld_pos + 4'd1;
      end
    end else if (hdr_pos == POS_ENTRIES) begin
      if (fld_pos == ENTRY_FLAG) begin
        if (b[FORCED_BIT]) forced_tot = sat_add(forced_tot, 32'd1);
        ent_crop = b[CROP_BIT];
      end
      if (fld_pos == (ent_crop ? CROP_END : ENTRY_END)) begin
        fld_pos  = '0;
        ent_crop = 1'b0;
        ent_left = ent_left - 8'd1;
        if (ent_left == 8'd0) hdr_pos = POS_SKIP;
      end else begin
        fld_pos = fld_pos + 4'd1;
      end
    end
    // payload used up: next byte is a header whatever was left unfinished
    if (pay_left == 16'd0) begin
      hdr_pos  = HDR_MAGIC_HI;
      fld_pos  = '0;
      ent_left = '0;
      ent_crop = 1'b0;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    report_t rep;
    if (err == STATUS_OK) begin
      if (hdr_pos <= POS_LAST_HDR) parse_header_byte(b);
      else parse_payload_byte(b);
    end
    if (last) begin
      rep.forced  = forced_tot;
      rep.objects = object_tot;
      rep.status  = err;
      if (err == STATUS_OK &&
          ((hdr_pos > HDR_MAGIC_HI && hdr_pos <= POS_LAST_HDR) || hdr_pos == POS_FIELDS))
        rep.status = STATUS_TRUNC;
      if (rep.status == STATUS_BAD_MAGIC) n_bad++;
      if (rep.status == STATUS_TRUNC) n_trunc++;
      pending_reports.push_back(rep);
      clear_parser();
    end
  endtask

  task automatic check_report();
    report_t want;
    if (pending_reports.size() == 0) begin
      fails++;
      $display("%0t: unexpected word, expected none, got forced %0d objects %0d status %0d",
               $time, out_forced_count, out_object_count, out_parse_status);
    end else begin
      want = pending_reports.pop_front();
      checked++;
      if (out_forced_count !== want.forced) begin
        fails++;
        $display("%0t: forced_count expected %0d got %0d",
                 $time, want.forced, out_forced_count);
      end
      if (out_object_count !== want.objects) begin
        fails++;
        $display("%0t: object_count expected %0d got %0d",
                 $time, want.objects, out_object_count);
      end
      if (out_parse_status !== want.status) begin
        fails++;
        $display("%0t: parse_status expected %0d got %0d",
                 $time, want.status, out_parse_status);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      magic_q     = MAGIC_RESET;
      comp_type_q = COMP_TYPE_RESET;
      clear_parser();
      pending_reports.delete();
      fails   = 0;
      checked = 0;
      n_bad   = 0;
      n_trunc = 0;
    end else begin
      if (out_valid && !out_stall) check_report();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_MAGIC) magic_q = cfg_data;
        else if (cfg_index == REG_COMP_TYPE) comp_type_q = cfg_data[7:0];
      end
      if (in_valid && !in_stall) parse_byte(in_data_byte, in_last_byte);
    end
    fail_count      <= fails;
    reports_pending <= pending_reports.size();
    reports_checked <= checked;
    bad_magic_seen  <= n_bad;
    trunc_seen      <= n_trunc;
  end

endmodule

[tb/tb_subtitle_forced_object_counter.sv]
// top of the subtitle forced object counter testbench: clock, reset, segment
// stream stimulus over several config and idle phases, verdict
// depends on sfoc_pkg, subtitle_forced_object_counter and sfoc_report_checker
module tb_subtitle_forced_object_counter;
  timeunit 1ns;
  timeprecision 1ps;
  import sfoc_pkg::*;

  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 280;
  localparam int PHASE_STREAMS = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic [7:0]           in_data_byte = '0;
  logic                 in_last_byte = 1'b0;
  logic                 out_stall    = 1'b0;
  logic                 cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [15:0]          cfg_data     = '0;

  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_forced_count;
  logic [31:0] out_object_count;
  logic [1:0]  out_parse_status;
  logic        cfg_ready;

  int fail_count, reports_pending, reports_checked, bad_magic_seen, trunc_seen;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          streams_sent = 0;
  logic [15:0] cur_magic;
  logic [7:0]  cur_ctype;
  logic [7:0]  stream_q[$];

  subtitle_forced_object_counter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_forced_count (out_forced_count),
    .out_object_count (out_object_count),
    .out_parse_status (out_parse_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  sfoc_report_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_forced_count (out_forced_count),
    .out_object_count (out_object_count),
    .out_parse_status (out_parse_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .reports_pending  (reports_pending),
    .reports_checked  (reports_checked),
    .bad_magic_seen   (bad_magic_seen),
    .trunc_seen       (trunc_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: run stopped at the cycle limit, %0d reports still due",
               $time, reports_pending);
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid stays high between back-to-back bytes, it only drops while idling
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_stream();
    int i;
    for (i = 0; i < stream_q.size(); i++)
      push_byte(stream_q[i], i == stream_q.size() - 1);
    streams_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [15:0] magic, input logic [7:0] ctype);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MAGIC;
    cfg_data  <= magic;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_COMP_TYPE;
    cfg_data  <= {8'($urandom_range(255)), ctype};
    do @(posedge clk); while (!cfg_ready);
    // an index past the list must leave both registers alone
    cfg_index <= $urandom_range(1) ? REG_SPARE_A : REG_SPARE_B;
    cfg_data  <= 16'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_magic = magic;
    cur_ctype = ctype;
  endtask

  task automatic add_header(input logic [15:0] magic, input logic [7:0] kind,
                            input logic [15:0] size);
    stream_q.push_back(magic[15:8]);
    stream_q.push_back(magic[7:0]);
    repeat (8) stream_q.push_back(8'($urandom));
    stream_q.push_back(kind);
    stream_q.push_back(size[15:8]);
    stream_q.push_back(size[7:0]);
  endtask

  task automatic add_composition();
    logic [7:0] pay[$];
    logic [7:0] flag;
    int n_obj, size, i;
    n_obj = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(4);
    repeat (FIELD_LAST) pay.push_back(8'($urandom));
    pay.push_back(8'(n_obj));
    for (i = 0; i < n_obj && pay.size() < 120; i++) begin
      flag = 8'($urandom);
      repeat (ENTRY_FLAG) pay.push_back(8'($urandom));
      pay.push_back(flag);
      repeat (ENTRY_END - ENTRY_FLAG) pay.push_back(8'($urandom));
      if (flag[CROP_BIT]) repeat (CROP_END - ENTRY_END) pay.push_back(8'($urandom));
    end
    case ($urandom_range(9))
      0:       size = $urandom_range(pay.size());
      1:       size = pay.size() + $urandom_range(1, 10);
      2:       size = $urandom_range(pay.size() + 1, 65535);
      default: size = pay.size();
    endcase
    add_header(cur_magic, cur_ctype, 16'(size));
    for (i = 0; i < size && i < pay.size() + 10; i++)
      stream_q.push_back(i < pay.size() ? pay[i] : 8'($urandom));
  endtask

  task automatic add_other();
    int size, n_send;
    size   = ($urandom_range(15) == 0) ? $urandom_range(256, 65535) : $urandom_range(24);
    n_send = (size > 24) ? $urandom_range(1, 24) : size;
    add_header(cur_magic, 8'($urandom), 16'(size));
    repeat (n_send) stream_q.push_back(8'($urandom));
  endtask

  task automatic build_random_stream();
    int pick, cut;
    stream_q.delete();
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 20)) stream_q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(3) != 0) add_composition();
        else add_other();
      end
      if (pick < 20) begin
        cut = $urandom_range(1) ? $urandom_range(1) : $urandom_range(stream_q.size() - 1);
        stream_q[cut] = stream_q[cut] ^ 8'($urandom_range(1, 255));
      end else if (pick < 35) begin
        cut = $urandom_range(1, stream_q.size());
        while (stream_q.size() > cut) void'(stream_q.pop_back());
      end
    end
  endtask

  task automatic run_directed();
    // wrong first magic byte, all ones
    stream_q.delete();
    stream_q.push_back(8'hFF);
    send_stream();
    // stream ends right after the magic
    stream_q.delete();
    stream_q.push_back(cur_magic[15:8]);
    stream_q.push_back(cur_magic[7:0]);
    send_stream();
    // empty composition payload goes straight back to the header
    stream_q.delete();
    add_header(cur_magic, cur_ctype, 16'd0);
    send_stream();
    // count of two, payload runs out inside a forced cropped entry
    stream_q.delete();
    add_header(cur_magic, cur_ctype, 16'd20);
    repeat (FIELD_LAST) stream_q.push_back(8'hFF);
    stream_q.push_back(8'd2);
    repeat (ENTRY_FLAG) stream_q.push_back(8'h00);
    stream_q.push_back(8'hC0);
    repeat (5) stream_q.push_back(8'h00);
    send_stream();
    // stream ends inside the composition fields
    stream_q.delete();
    add_header(cur_magic, cur_ctype, 16'd30);
    repeat (3) stream_q.push_back(8'h55);
    send_stream();
  endtask

  task automatic run_phase(input logic [15:0] magic, input logic [7:0] ctype,
                           input int idle, input int stall);
    int start_bytes, start_streams;
    write_regs(magic, ctype);
    idle_pct      = idle;
    stall_pct     = stall;
    start_bytes   = bytes_sent;
    start_streams = streams_sent;
    while (bytes_sent - start_bytes < PHASE_BYTES ||
           streams_sent - start_streams < PHASE_STREAMS) begin
      build_random_stream();
      send_stream();
      if ($urandom_range(19) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    cur_magic = MAGIC_RESET;
    cur_ctype = COMP_TYPE_RESET;
    stall_pct = 30;
    run_directed();
    wait_drained();
    run_phase(MAGIC_RESET, COMP_TYPE_RESET, 0, 0);
    run_phase(16'h0000, 8'h00, 84, 0);
    run_phase(16'hFFFF, 8'hFF, 0, 84);
    run_phase(16'($urandom), 8'($urandom), 19, 19);
    run_phase(16'($urandom), 8'($urandom), $urandom_range(40), $urandom_range(40));
    $display("sent %0d bytes in %0d streams over five config and idle phases",
             bytes_sent, streams_sent);
    $display("checked %0d reports, %0d with bad magic, %0d truncated",
             reports_checked, bad_magic_seen, trunc_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
